// ===== rtl/core/hq_pkg.sv =====
// Shared sizes, entry type and codes for the binary min-heap queue.
package hq_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 16;
	localparam int PRIO_WIDTH = 16;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CHILD_W = IDX_W + 2;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic [PRIO_WIDTH-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/hq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/binary_min_heap_queue.sv =====
// Binary min-heap priority queue: heap array in RAM, sift sequencer, result register.
//
//  channel | valid     | ready     | word
//  --------+-----------+-----------+--------------------------------------
//  in      | in_valid  | in_ready  | req_type, payload, prio
//  out     | out_valid | out_ready | status, out_payload, out_prio, fill
//
// One request at a time; the heap RAM has one read and one write port.
// Insert: climbs at most 6 levels toward the root, stopping early at a parent that is not greater.
// Remove: sinks at most 5 levels toward a leaf, stopping early at a child that is not smaller.
// Removing the last entry skips the sift-down; refused words go straight to the result.
// Reset clears the fill count, sequencer and out_valid only; heap RAM needs no clearing.
// A result waiting on out_ready holds the sequencer before it returns to idle.
module binary_min_heap_queue
	import hq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [DATA_WIDTH-1:0] payload,
	input  logic [PRIO_WIDTH-1:0] prio,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] out_payload,
	output logic [PRIO_WIDTH-1:0] out_prio,
	output logic [CNT_W-1:0]      fill
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_UP_RD  = 4'd1;
	localparam logic [3:0] S_UP_CMP = 4'd2;
	localparam logic [3:0] S_RM_RD0 = 4'd3;
	localparam logic [3:0] S_RM_RD1 = 4'd4;
	localparam logic [3:0] S_DN_LD  = 4'd5;
	localparam logic [3:0] S_DN_RDL = 4'd6;
	localparam logic [3:0] S_DN_RDR = 4'd7;
	localparam logic [3:0] S_DN_DEC = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] pos_q;
	entry_t           ent_q;     // entry being sifted, held out of the RAM
	entry_t           child_q;   // left child during sift-down
	logic             has_r_q;
	logic [1:0]       res_status_q;
	entry_t           root_q;

	logic             out_valid_q;
	logic [1:0]       out_status_q;
	entry_t           out_ent_q;
	logic [CNT_W-1:0] out_fill_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	logic [CHILD_W-1:0] l_idx;
	logic [CHILD_W-1:0] r_idx;
	logic [CHILD_W-1:0] n_ext;
	logic               has_l;
	logic               has_r;
	logic [IDX_W-1:0]   parent_idx;
	logic               pick_r;
	entry_t             cand;
	logic [IDX_W-1:0]   cand_idx;
	logic               sink;
	logic               rise;
	logic               accept;
	logic               out_free;

	hq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_heap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign l_idx      = (CHILD_W'(pos_q) << 1) + CHILD_W'(1);
	assign r_idx      = l_idx + CHILD_W'(1);
	assign n_ext      = CHILD_W'(cnt_q);
	assign has_l      = (l_idx < n_ext);
	assign has_r      = (r_idx < n_ext);
	assign parent_idx = (pos_q - IDX_W'(1)) >> 1;

	// left child wins a tie; the entry only sinks past a strictly smaller child
	assign pick_r   = has_r_q && (ram_rdata.prio < child_q.prio);
	assign cand     = pick_r ? ram_rdata : child_q;
	assign cand_idx = pick_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
	assign sink     = (cand.prio < ent_q.prio);
	assign rise     = (ram_rdata.prio > ent_q.prio);

	// Each write lands before any later read of that slot, so no forwarding.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = ent_q;
		ram_raddr = parent_idx;
		unique case (state_q)
			S_UP_RD: begin
				ram_raddr = parent_idx;
				ram_we    = (pos_q == '0);
			end
			S_UP_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = rise ? ram_rdata : ent_q;
			end
			S_RM_RD0: begin
				ram_raddr = '0;
			end
			S_RM_RD1: begin
				ram_raddr = cnt_q[IDX_W-1:0];
			end
			S_DN_RDL: begin
				ram_raddr = l_idx[IDX_W-1:0];
				ram_we    = !has_l;
			end
			S_DN_RDR: begin
				ram_raddr = r_idx[IDX_W-1:0];
			end
			S_DN_DEC: begin
				ram_we    = 1'b1;
				ram_wdata = sink ? cand : ent_q;
			end
			S_IDLE, S_DN_LD, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_INSERT) begin
							if (cnt_q == CNT_W'(CAPACITY)) begin
								state_q <= S_FIN;
							end else begin
								cnt_q   <= cnt_q + CNT_W'(1);
								state_q <= S_UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								state_q <= S_FIN;
							end else begin
								cnt_q   <= cnt_q - CNT_W'(1);
								state_q <= S_RM_RD0;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= rise ? S_UP_RD : S_FIN;
				end
				S_RM_RD0: begin
					state_q <= S_RM_RD1;
				end
				S_RM_RD1: begin
					state_q <= (cnt_q == '0) ? S_FIN : S_DN_LD;
				end
				S_DN_LD: begin
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: begin
					state_q <= has_l ? S_DN_RDR : S_FIN;
				end
				S_DN_RDR: begin
					state_q <= S_DN_DEC;
				end
				S_DN_DEC: begin
					state_q <= sink ? S_DN_RDL : S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ent_q.data <= payload;
					ent_q.prio <= prio;
					pos_q      <= cnt_q[IDX_W-1:0];
					root_q     <= '0;
					if (req_type == REQ_INSERT) begin
						res_status_q <= (cnt_q == CNT_W'(CAPACITY)) ? ST_FULL : ST_DONE;
					end else begin
						res_status_q <= (cnt_q == '0) ? ST_EMPTY : ST_DONE;
					end
				end
			end
			S_UP_CMP: begin
				if (rise) begin
					pos_q <= parent_idx;
				end
			end
			S_RM_RD1: begin
				root_q <= ram_rdata;
			end
			S_DN_LD: begin
				ent_q <= ram_rdata;
				pos_q <= '0;
			end
			S_DN_RDR: begin
				child_q <= ram_rdata;
				has_r_q <= has_r;
			end
			S_DN_DEC: begin
				if (sink) begin
					pos_q <= cand_idx;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_ent_q    <= root_q;
					out_fill_q   <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign out_payload = out_ent_q.data;
	assign out_prio    = out_ent_q.prio;
	assign fill        = out_fill_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_INSERT && cnt_q != CNT_W'(CAPACITY))
		|=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the heap");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> out_fill_q == CNT_W'(CAPACITY))
		else $error("full refusal with room left");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_EMPTY) |-> out_fill_q == '0)
		else $error("empty refusal with entries held");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |-> !ram_we)
		else $error("heap written outside a sift");

endmodule
